// ----- design/mwg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mwg_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 256;
    localparam int SAMPLE_WIDTH_DEF     = 16;
    localparam int WAVE_W               = 16;
    localparam int TICK_W               = 32;
    localparam int PHASE_W              = 32;
    localparam int AMP_W                = 16;
    localparam int CFG_DATA_W           = 32;
    localparam int CFG_INDEX_W          = 3;
    localparam int ROM_W                = 15;
    localparam int QUEUE_DEPTH          = 4;

    // quarter turn in radians, Q30
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    typedef enum logic [1:0] {
        MODE_SINE      = 2'd0,
        MODE_SAW_UP    = 2'd1,
        MODE_SAW_DOWN  = 2'd2,
        MODE_SQUARE    = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WAVE_MODE    = 3'd0,
        REG_AMPLITUDE    = 3'd1,
        REG_PHASE_STEP   = 3'd2,
        REG_PHASE_OFFSET = 3'd3,
        REG_WINDOW_START = 3'd4,
        REG_WINDOW_END   = 3'd5
    } reg_index_t;

    typedef struct packed {
        mode_t                     wave_mode;
        logic signed [AMP_W-1:0]   amplitude;
        logic [PHASE_W-1:0]        phase_step;
        logic [PHASE_W-1:0]        phase_offset;
        logic [TICK_W-1:0]         window_start;
        logic [TICK_W-1:0]         window_end;
    } cfg_t;

    // sin(x) for x in Q30, Taylor series to x^13, result in Q1.15
    function automatic logic [ROM_W-1:0] sine_q15(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] q;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 0; n < 6; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n & 1) == 0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        q = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
        if (q > 64'sd32767)
            q = 64'sd32767;
        return q[ROM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/mwg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwg_regs
    import mwg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WAVE_MODE:    cfg_next.wave_mode    = mode_t'(cfg_data[1:0]);
                REG_AMPLITUDE:    cfg_next.amplitude    = $signed(cfg_data[AMP_W-1:0]);
                REG_PHASE_STEP:   cfg_next.phase_step   = cfg_data[PHASE_W-1:0];
                REG_PHASE_OFFSET: cfg_next.phase_offset = cfg_data[PHASE_W-1:0];
                REG_WINDOW_START: cfg_next.window_start = cfg_data[TICK_W-1:0];
                REG_WINDOW_END:   cfg_next.window_end   = cfg_data[TICK_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/mwg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwg_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("request popped from an empty queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill count out of step with pushes");
`endif

endmodule

`default_nettype wire

// ----- design/mwg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwg_front
    import mwg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [TICK_W-1:0] time_tick,
    output logic                   push,
    output logic [PHASE_W-1:0]     push_data,
    input  wire logic              queue_full
);

    logic               f1_valid_reg, f1_valid_next;
    logic [TICK_W-1:0]  f1_tick_reg;
    logic               f2_valid_reg, f2_valid_next;
    logic [PHASE_W-1:0] f2_mult_reg, f2_mult_next;
    logic               advance;
    logic               accept;
    logic               in_window;

    // the front holds only while its last stage has a request and the queue is full
    assign advance  = !(f2_valid_reg && queue_full);
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    // ticks outside the window are dropped here and never reach the queue
    assign in_window = ((time_tick > cfg.window_start) && (time_tick < cfg.window_end))
                     || (cfg.window_end < cfg.window_start);

    always_comb
    begin
        f1_valid_next = accept && in_window;
        f2_valid_next = f1_valid_reg;
        f2_mult_next  = PHASE_W'(cfg.phase_step * f1_tick_reg);
    end

    assign push      = f2_valid_reg && advance;
    assign push_data = f2_mult_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_tick_reg <= time_tick;
            f2_mult_reg <= f2_mult_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/mwg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwg_back
    import mwg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               queue_not_empty,
    input  wire logic [PHASE_W-1:0] queue_data,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [WAVE_W-1:0]       wave_value
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IPRD_W = 30 + IDX_W;
    localparam int FAC_W  = 34;
    localparam int PRD_W  = AMP_W + FAC_W;
    localparam int SAT_W  = 34;

    function automatic logic [SINE_TABLE_DEPTH:0][ROM_W-1:0] build_rom();
        logic [SINE_TABLE_DEPTH:0][ROM_W-1:0] rom;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
            rom[k] = sine_q15((PI_HALF_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH));
        return rom;
    endfunction

    localparam logic [SINE_TABLE_DEPTH:0][ROM_W-1:0] SINE_ROM = build_rom();

    localparam logic signed [SAT_W-1:0] SAT_HI = (SAT_W'(1) <<< (SAMPLE_WIDTH - 1)) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    logic                     advance;

    logic                     b1_valid_reg;
    logic [PHASE_W-1:0]       b1_phase_reg, b1_phase_next;

    logic                     b2_valid_reg;
    logic signed [FAC_W-1:0]  b2_factor_reg, b2_factor_next;
    logic                     b2_sh32_reg, b2_sh32_next;

    logic                     b3_valid_reg;
    logic signed [PRD_W-1:0]  b3_prod_reg, b3_prod_next;
    logic                     b3_sh32_reg;

    logic                     out_valid_reg;
    logic [WAVE_W-1:0]        wave_value_reg, wave_value_next;

    logic [IPRD_W-1:0]        idx_prod;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         rom_addr;
    logic [FAC_W-1:0]         rom_val;
    logic signed [PRD_W-1:0]  rounded;
    logic signed [SAT_W-1:0]  sample;
    logic signed [SAT_W-1:0]  clipped;

    assign advance = !(out_valid_reg && out_stall);
    assign pop     = queue_not_empty && advance;

    // phase
    assign b1_phase_next = queue_data + cfg.phase_offset;

    // table address and multiplier operand
    always_comb
    begin
        idx_prod = {{IDX_W{1'b0}}, b1_phase_reg[29:0]} * IPRD_W'(SINE_TABLE_DEPTH);
        idx      = idx_prod[IPRD_W-1:30];
        if (idx > IDX_W'(SINE_TABLE_DEPTH))
            idx = IDX_W'(SINE_TABLE_DEPTH);
        // odd quadrants run the table backwards
        rom_addr = b1_phase_reg[30] ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
        rom_val  = FAC_W'(SINE_ROM[rom_addr]);
        b2_factor_next = '0;
        b2_sh32_next   = 1'b0;
        unique case (cfg.wave_mode)
            MODE_SINE:
            begin
                b2_factor_next = b1_phase_reg[31] ? -$signed(rom_val) : $signed(rom_val);
            end
            MODE_SAW_UP:
            begin
                b2_factor_next = $signed({2'b00, b1_phase_reg});
                b2_sh32_next   = 1'b1;
            end
            MODE_SAW_DOWN:
            begin
                b2_factor_next = $signed(FAC_W'(35'h1_0000_0000) - {2'b00, b1_phase_reg});
                b2_sh32_next   = 1'b1;
            end
            MODE_SQUARE:
            begin
                // times one in Q1.15, so the saturation catches a negated minimum
                b2_factor_next = b1_phase_reg[31] ? -FAC_W'(32768) : FAC_W'(32768);
            end
            default:
            begin
                b2_factor_next = '0;
                b2_sh32_next   = 1'b0;
            end
        endcase
    end

    assign b3_prod_next = cfg.amplitude * b2_factor_reg;

    // truncate toward zero, then clip to the sample range
    always_comb
    begin
        if (b3_sh32_reg)
            rounded = b3_prod_reg[PRD_W-1]
                    ? (b3_prod_reg + $signed(PRD_W'(33'h0_FFFF_FFFF))) >>> 32
                    : b3_prod_reg >>> 32;
        else
            rounded = b3_prod_reg[PRD_W-1]
                    ? (b3_prod_reg + $signed(PRD_W'(16'h7FFF))) >>> 15
                    : b3_prod_reg >>> 15;
        sample = rounded[SAT_W-1:0];
        if (sample > SAT_HI)
            clipped = SAT_HI;
        else if (sample < SAT_LO)
            clipped = SAT_LO;
        else
            clipped = sample;
        wave_value_next = clipped[WAVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg  <= pop;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_phase_reg   <= b1_phase_next;
            b2_factor_reg  <= b2_factor_next;
            b2_sh32_reg    <= b2_sh32_next;
            b3_prod_reg    <= b3_prod_next;
            b3_sh32_reg    <= b2_sh32_reg;
            wave_value_reg <= wave_value_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign wave_value = wave_value_reg;

`ifndef SYNTHESIS
    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(b3_valid_reg))
        else $error("result shown with no request behind it");

    a_drain_on_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(!b3_valid_reg && !out_stall))
        else $error("result dropped while the pipeline held a request");
`endif

endmodule

`default_nettype wire

// ----- design/multi_waveform_generator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Waveform generator (DDS style). Each accepted time_tick gives at most one
// wave_value: ticks outside the window set by window_start/window_end are
// dropped in the front pipeline, the rest make a sample in the mode chosen by
// wave_mode (sine from a quarter-wave table, rising or falling sawtooth, or
// square), scaled by amplitude. One tick is taken per clock and one sample is
// given per clock when out_stall stays low, as the back pipeline then moves one
// request a cycle through its multipliers.
// A request passes two front stages, a four-entry queue, three back stages
// and the output register. The queue lets the input keep flowing while the
// output is stalled, until its four entries are full. Configuration
// registers are written through cfg_write, cfg_index and cfg_data and should
// only change while no request is in flight.
module multi_waveform_generator_top
    import mwg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [TICK_W-1:0]      time_tick,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [WAVE_W-1:0]           wave_value
);

    cfg_t               cfg;
    logic               push;
    logic [PHASE_W-1:0] push_data;
    logic               queue_full;
    logic               pop;
    logic [PHASE_W-1:0] pop_data;
    logic               queue_not_empty;

    mwg_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mwg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .time_tick  (time_tick),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    mwg_queue #(
        .WIDTH (PHASE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (queue_not_empty)
    );

    mwg_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .queue_not_empty (queue_not_empty),
        .queue_data      (pop_data),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .wave_value      (wave_value)
    );

endmodule

`default_nettype wire
